// ===== rtl/dqph_pkg.sv =====
// ----------------------------------------------------------------------------
// dqph_pkg
// types, offsets and hash functions shared by the dns query parser blocks
// ----------------------------------------------------------------------------
package dqph_pkg;

    localparam int unsigned NAME_CAP_DEF = 255;

    localparam logic [10:0] OFF_MAX        = 11'd2047;
    localparam logic [10:0] OFF_SRC_IP_LO  = 11'd12;
    localparam logic [10:0] OFF_SRC_IP_HI  = 11'd15;
    localparam logic [10:0] OFF_DST_IP_LO  = 11'd16;
    localparam logic [10:0] OFF_DST_IP_HI  = 11'd19;
    localparam logic [10:0] OFF_SRC_PORT   = 11'd20;
    localparam logic [10:0] OFF_DST_PORT   = 11'd22;
    localparam logic [10:0] OFF_QUERY_ID   = 11'd28;
    localparam logic [10:0] OFF_NAME_START = 11'd40;

    localparam logic [7:0] CHAR_DOT = 8'h2e;

    localparam logic REC_CHAR    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_EARLY_END = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_HDR  = 3'b001,
        PH_NAME = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef struct packed {
        logic        rec_type;
        logic [7:0]  name_char;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] query_id;
        logic [15:0] name_hash;
        logic [7:0]  name_length;
        logic [1:0]  status;
    } t_result;

    function automatic logic [15:0] hash_mix(input logic [15:0] h, input logic [7:0] c);
        logic [15:0] s;
        logic [15:0] h1;
        logic [15:0] h2;
        s  = {{8{c[7]}}, c};
        h1 = h + s;
        h2 = h1 + (h1 << 10);
        return h2 ^ (h2 >> 6);
    endfunction

    function automatic logic [15:0] hash_final(input logic [15:0] h);
        logic [15:0] f1;
        logic [15:0] f2;
        f1 = h + (h << 3);
        f2 = f1 ^ (f1 >> 11);
        return f2 + (f2 << 15);
    endfunction

endpackage

// ===== rtl/dqph_in_if.sv =====
// ----------------------------------------------------------------------------
// dqph_in_if
// packet byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface dqph_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       end_of_packet;

    modport source (output valid, output pkt_byte, output end_of_packet, input ready);
    modport sink   (input valid, input pkt_byte, input end_of_packet, output ready);
endinterface

// ===== rtl/dqph_out_if.sv =====
// ----------------------------------------------------------------------------
// dqph_out_if
// result record channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface dqph_out_if;
    logic        valid;
    logic        ready;
    logic        rec_type;
    logic [7:0]  name_char;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] query_id;
    logic [15:0] name_hash;
    logic [7:0]  name_length;
    logic [1:0]  status;

    modport source (
        output valid, output rec_type, output name_char, output src_ip, output dst_ip,
        output src_port, output dst_port, output query_id, output name_hash,
        output name_length, output status, input ready
    );
    modport sink (
        input valid, input rec_type, input name_char, input src_ip, input dst_ip,
        input src_port, input dst_port, input query_id, input name_hash,
        input name_length, input status, output ready
    );
endinterface

// ===== rtl/dqph_parser.sv =====
// ----------------------------------------------------------------------------
// dqph_parser
// header capture, label walk and running hash, one byte per accepted request
// ----------------------------------------------------------------------------
module dqph_parser #(
    parameter int unsigned NAME_CAP = dqph_pkg::NAME_CAP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_pkt_byte,
    input  logic              i_end_of_packet,
    output logic              o_res_valid,
    output dqph_pkg::t_result o_res
);
    import dqph_pkg::*;

    localparam logic [7:0] CAP = 8'(NAME_CAP);

    t_phase      r_phase,  n_phase;
    logic [10:0] r_off,    n_off;
    logic [7:0]  r_lab,    n_lab;
    logic        r_first,  n_first;
    logic [31:0] r_sa,     n_sa;
    logic [31:0] r_da,     n_da;
    logic [15:0] r_sp,     n_sp;
    logic [15:0] r_dp,     n_dp;
    logic [15:0] r_id,     n_id;
    logic [15:0] r_hash,   n_hash;
    logic        r_stop,   n_stop;
    logic [7:0]  r_kept,   n_kept;
    logic        r_tl,     n_tl;

    logic        name_act;
    logic        has_char;
    logic [7:0]  c;
    logic        summary;
    t_status     sum_status;

    always_comb begin
        n_phase  = r_phase;
        n_lab    = r_lab;
        n_first  = r_first;
        n_sa     = r_sa;
        n_da     = r_da;
        n_sp     = r_sp;
        n_dp     = r_dp;
        n_id     = r_id;
        n_hash   = r_hash;
        n_stop   = r_stop;
        n_kept   = r_kept;
        n_tl     = r_tl;
        n_off    = (r_off != OFF_MAX) ? r_off + 11'd1 : r_off;
        name_act = 1'b0;
        has_char = 1'b0;
        c        = '0;
        summary  = 1'b0;
        sum_status = ST_OK;
        o_res_valid = 1'b0;

        case (r_phase)
            PH_HDR: begin
                if (r_off >= OFF_SRC_IP_LO && r_off <= OFF_SRC_IP_HI) begin
                    n_sa = {r_sa[23:0], i_pkt_byte};
                end else if (r_off >= OFF_DST_IP_LO && r_off <= OFF_DST_IP_HI) begin
                    n_da = {r_da[23:0], i_pkt_byte};
                end else if (r_off[10:1] == OFF_SRC_PORT[10:1]) begin
                    n_sp = {r_sp[7:0], i_pkt_byte};
                end else if (r_off[10:1] == OFF_DST_PORT[10:1]) begin
                    n_dp = {r_dp[7:0], i_pkt_byte};
                end else if (r_off[10:1] == OFF_QUERY_ID[10:1]) begin
                    n_id = {r_id[7:0], i_pkt_byte};
                end else if (r_off >= OFF_NAME_START) begin
                    n_phase  = PH_NAME;
                    name_act = 1'b1;
                end
            end
            PH_NAME: begin
                name_act = 1'b1;
            end
            default: begin
                name_act = 1'b0;
            end
        endcase

        if (name_act) begin
            if (r_lab == 8'd0 && i_pkt_byte == 8'd0) begin
                summary    = 1'b1;
                sum_status = r_tl ? ST_TOO_LONG : ST_OK;
                n_phase    = PH_DONE;
            end else if (!i_end_of_packet) begin
                if (r_lab != 8'd0) begin
                    c        = i_pkt_byte;
                    has_char = 1'b1;
                    n_lab    = r_lab - 8'd1;
                end else begin
                    n_lab   = i_pkt_byte;
                    c       = CHAR_DOT;
                    has_char = r_first;
                    n_first = 1'b1;
                end
                if (has_char) begin
                    if (r_kept < CAP) begin
                        n_kept      = r_kept + 8'd1;
                        o_res_valid = 1'b1;
                        if (!r_stop) begin
                            if (c == 8'd0) begin
                                n_stop = 1'b1;
                            end else begin
                                n_hash = hash_mix(r_hash, c);
                            end
                        end
                    end else begin
                        n_tl = 1'b1;
                    end
                end
            end
        end

        if (i_end_of_packet && !summary && !o_res_valid && r_phase != PH_DONE) begin
            summary    = 1'b1;
            sum_status = ST_EARLY_END;
        end

        if (summary) begin
            o_res_valid = 1'b1;
        end

        o_res             = '0;
        o_res.rec_type    = summary ? REC_SUMMARY : REC_CHAR;
        if (summary) begin
            o_res.src_ip      = n_sa;
            o_res.dst_ip      = n_da;
            o_res.src_port    = n_sp;
            o_res.dst_port    = n_dp;
            o_res.query_id    = n_id;
            o_res.name_hash   = hash_final(r_hash);
            o_res.name_length = n_kept;
            o_res.status      = sum_status;
        end else begin
            o_res.name_char   = c;
        end

        o_res_valid = o_res_valid & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_packet)) begin
            r_phase <= PH_HDR;
            r_off   <= '0;
            r_lab   <= '0;
            r_first <= 1'b0;
            r_sa    <= '0;
            r_da    <= '0;
            r_sp    <= '0;
            r_dp    <= '0;
            r_id    <= '0;
            r_hash  <= '0;
            r_stop  <= 1'b0;
            r_kept  <= '0;
            r_tl    <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_lab   <= n_lab;
            r_first <= n_first;
            r_sa    <= n_sa;
            r_da    <= n_da;
            r_sp    <= n_sp;
            r_dp    <= n_dp;
            r_id    <= n_id;
            r_hash  <= n_hash;
            r_stop  <= n_stop;
            r_kept  <= n_kept;
            r_tl    <= n_tl;
        end
    end

endmodule

// ===== rtl/dqph_out_reg.sv =====
// ----------------------------------------------------------------------------
// dqph_out_reg
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module dqph_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  dqph_pkg::t_result i_res,
    output logic              o_take,
    dqph_out_if.source        o_res
);
    import dqph_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_take = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.rec_type    = r_data.rec_type;
    assign o_res.name_char   = r_data.name_char;
    assign o_res.src_ip      = r_data.src_ip;
    assign o_res.dst_ip      = r_data.dst_ip;
    assign o_res.src_port    = r_data.src_port;
    assign o_res.dst_port    = r_data.dst_port;
    assign o_res.query_id    = r_data.query_id;
    assign o_res.name_hash   = r_data.name_hash;
    assign o_res.name_length = r_data.name_length;
    assign o_res.status      = r_data.status;

endmodule

// ===== rtl/dns_query_parse_hash.sv =====
// ----------------------------------------------------------------------------
// dns_query_parse_hash
// streaming ipv4/udp dns query parser with query name walk and 16-bit hash
//
//   channel  dir  payload                                     records
//   i_req    in   pkt_byte, end_of_packet                     one byte each
//   o_res    out  rec_type, name_char, addresses, ports, id,  zero or one
//                 name_hash, name_length, status              per byte
//
// one byte per cycle unless stalled; parser state and result register are
// the only stages, so a result appears in the cycle after its byte is taken
// i_req.ready drops only while a result is held and o_res.ready is low
// synchronous active-low reset; parser state also clears after the last byte
// ----------------------------------------------------------------------------
module dns_query_parse_hash #(
    parameter int unsigned NAME_CAP = dqph_pkg::NAME_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqph_in_if.sink    i_req,
    dqph_out_if.source o_res
);
    import dqph_pkg::*;

    logic    take;
    logic    accept;
    logic    res_valid;
    t_result res;

    assign i_req.ready = take;
    assign accept      = i_req.valid && take;

    dqph_parser #(
        .NAME_CAP (NAME_CAP)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_pkt_byte      (i_req.pkt_byte),
        .i_end_of_packet (i_req.end_of_packet),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    dqph_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_take      (take),
        .o_res       (o_res)
    );

    a_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_req.ready
    ) else $error("request taken while result stalled");

    a_char_rec_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rec_type == REC_CHAR) |->
            (o_res.name_length == 8'd0 && o_res.status == ST_OK && o_res.name_hash == 16'd0)
    ) else $error("character record carries summary fields");

    a_length_capped: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.name_length <= 8'(NAME_CAP))
    ) else $error("name length beyond cap");

    a_result_follows_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> accept
    ) else $error("result without accepted request");

endmodule
